>>> src/tnui_pkg.sv
`default_nettype none

package tnui_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int EDGE_COUNT = 8192;

    // Address widths of the internal stores.
    localparam int OA_W  = $clog2(NODE_COUNT + 1);   // offset table
    localparam int EA_W  = $clog2(EDGE_COUNT);       // edge tables
    localparam int MA_W  = $clog2(NODE_COUNT);       // mark flags and marked list
    localparam int CNT_W = $clog2(NODE_COUNT + 1);   // marked count

    localparam int OFS_W  = 14;
    localparam int NODE_W = 10;
    localparam int TIME_W = 32;
    localparam int ADDR_W = 13;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        FUNC_WR_OFS  = 2'd0,
        FUNC_WR_EDGE = 2'd1,
        FUNC_QUERY   = 2'd2
    } func_t;

    typedef struct packed {
        func_t                     func;
        logic [ADDR_W-1:0]         table_addr;
        logic [OFS_W-1:0]          offset_value;
        logic [NODE_W-1:0]         neighbor_id;
        logic signed [TIME_W-1:0]  edge_time;
        logic [NODE_W-1:0]         node_a;
        logic [NODE_W-1:0]         node_b;
        logic signed [TIME_W-1:0]  cutoff_time;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] union_count;
        logic [COUNT_W-1:0] intersect_count;
    } res_t;

endpackage

`default_nettype wire

>>> src/tnui_ram.sv
`default_nettype none

// Simple dual-port memory: one write port, one read port with registered data.
module tnui_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/temporal_neighbor_union_intersect_core.sv
`default_nettype none

// Temporal common-neighbor counter over a compressed adjacency graph.
// Requests arrive on req (valid/ready). A request with func set to write an
// offset or an edge entry updates the offset table or the edge tables in the
// cycle it is accepted and returns nothing. A query request walks the edge
// list of node_a and then of node_b, stopping each walk at the first edge at
// or after cutoff_time, and returns one result on res (valid/ready) holding
// the union and intersection counts of the neighbors seen.
// Each node of a query first fetches its offsets, then visits its edges
// one at a time (an edge whose neighbor is out of range is passed over),
// and its walk ends at the end of its list or at the first late edge.
// A clearing pass then resets the mark of each distinct neighbor, and the
// result is posted. Every step goes through the single read port of one
// of the memories, so one query is in flight and req_ready is low meanwhile.
// Reset: after rst_n is released the mark-flag memory is swept to zero,
// one entry per cycle, over its NODE_COUNT (1024) entries; req_ready
// stays low during that pass. Table contents are not cleared and must be
// written before a query reads them.
// Stall: the result sits in an output register. A write request is accepted
// while a result waits; a query finishes its walk and then holds until the
// output register is free.
module temporal_neighbor_union_intersect_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire tnui_pkg::req_t req,
    output logic                res_valid,
    input  wire logic           res_ready,
    output tnui_pkg::res_t      res
);

    import tnui_pkg::*;

    // Mark flag encodings.
    localparam logic [1:0] MARK_NONE = 2'b00;
    localparam logic [1:0] MARK_A    = 2'b01;
    localparam logic [1:0] MARK_B    = 2'b10;
    localparam logic [1:0] MARK_BOTH = 2'b11;

    typedef enum logic [10:0] {
        S_SWEEP    = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_OFS_A    = 11'b00000000100,
        S_OFS_B    = 11'b00000001000,
        S_OFS_C    = 11'b00000010000,
        S_EDGE_RD  = 11'b00000100000,
        S_EDGE_CHK = 11'b00001000000,
        S_MARK_CHK = 11'b00010000000,
        S_CLR_RD   = 11'b00100000000,
        S_CLR_WR   = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Control registers.
    logic             phase_reg, phase_next;       // 0 walks node_a, 1 walks node_b
    logic [MA_W-1:0]  sweep_reg, sweep_next;
    logic [CNT_W-1:0] mcnt_reg, mcnt_next;         // entries in the marked list
    logic [CNT_W-1:0] clr_reg, clr_next;           // clearing index into the list
    logic             out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [OFS_W-1:0]         ptr_reg, ptr_next;
    logic [OFS_W-1:0]         end_reg, end_next;
    logic [NODE_W-1:0]        nb_reg, nb_next;
    logic [COUNT_W-1:0]       uni_reg, uni_next;
    logic [COUNT_W-1:0]       inter_reg, inter_next;
    logic [NODE_W-1:0]        node_a_reg, node_a_next;
    logic [NODE_W-1:0]        node_b_reg, node_b_next;
    logic signed [TIME_W-1:0] cutoff_reg, cutoff_next;
    res_t                     out_reg, out_next;

    // Memory ports.
    logic                       ofs_we;
    logic [OA_W-1:0]            ofs_waddr, ofs_raddr;
    logic [OFS_W-1:0]           ofs_rdata;
    logic                       edge_we;
    logic [EA_W-1:0]            edge_waddr, edge_raddr;
    logic [NODE_W+TIME_W-1:0]   edge_wdata, edge_rdata;
    logic                       mark_we;
    logic [MA_W-1:0]            mark_waddr, mark_raddr;
    logic [1:0]                 mark_wdata, mark_rdata;
    logic                       list_we;
    logic [MA_W-1:0]            list_waddr, list_raddr;
    logic [NODE_W-1:0]          list_rdata;

    tnui_ram #(.DEPTH(NODE_COUNT + 1), .WIDTH(OFS_W)) u_ofs_ram (
        .clk   (clk),
        .we    (ofs_we),
        .waddr (ofs_waddr),
        .wdata (req.offset_value),
        .raddr (ofs_raddr),
        .rdata (ofs_rdata)
    );

    tnui_ram #(.DEPTH(EDGE_COUNT), .WIDTH(NODE_W + TIME_W)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    tnui_ram #(.DEPTH(NODE_COUNT), .WIDTH(2)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    tnui_ram #(.DEPTH(NODE_COUNT), .WIDTH(NODE_W)) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (nb_reg),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    // Fields read back from the edge tables, and the node and mark of the walk.
    logic [NODE_W-1:0]        edge_nb;
    logic signed [TIME_W-1:0] edge_tm;
    logic [NODE_W-1:0]        cur_node;
    logic [1:0]               cur_bit;

    assign edge_nb  = edge_rdata[NODE_W+TIME_W-1:TIME_W];
    assign edge_tm  = $signed(edge_rdata[TIME_W-1:0]);
    assign cur_node = phase_reg ? node_b_reg : node_a_reg;
    assign cur_bit  = phase_reg ? MARK_B : MARK_A;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign edge_wdata = {req.neighbor_id, req.edge_time};

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        sweep_next     = sweep_reg;
        mcnt_next      = mcnt_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        nb_next        = nb_reg;
        uni_next       = uni_reg;
        inter_next     = inter_reg;
        node_a_next    = node_a_reg;
        node_b_next    = node_b_reg;
        cutoff_next    = cutoff_reg;
        out_next       = out_reg;

        ofs_we     = 1'b0;
        ofs_waddr  = OA_W'(req.table_addr);
        ofs_raddr  = OA_W'(cur_node);
        edge_we    = 1'b0;
        edge_waddr = EA_W'(req.table_addr);
        edge_raddr = EA_W'(ptr_reg);
        mark_we    = 1'b0;
        mark_waddr = MA_W'(nb_reg);
        mark_wdata = MARK_NONE;
        mark_raddr = MA_W'(edge_nb);
        list_we    = 1'b0;
        list_waddr = mcnt_reg[MA_W-1:0];
        list_raddr = clr_reg[MA_W-1:0];

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP:
            begin
                mark_we    = 1'b1;
                mark_waddr = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == MA_W'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.func)
                        FUNC_WR_OFS:
                        begin
                            ofs_we = (32'(req.table_addr) <= NODE_COUNT);
                        end
                        FUNC_WR_EDGE:
                        begin
                            edge_we = (32'(req.table_addr) < EDGE_COUNT);
                        end
                        FUNC_QUERY:
                        begin
                            node_a_next = req.node_a;
                            node_b_next = req.node_b;
                            cutoff_next = req.cutoff_time;
                            phase_next  = 1'b0;
                            uni_next    = '0;
                            inter_next  = '0;
                            state_next  = S_OFS_A;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_OFS_A:
            begin
                // A node outside the graph has an empty edge list.
                if (32'(cur_node) >= NODE_COUNT)
                begin
                    if (phase_reg)
                    begin
                        clr_next   = '0;
                        state_next = S_CLR_RD;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    ofs_raddr  = OA_W'(cur_node);
                    state_next = S_OFS_B;
                end
            end

            S_OFS_B:
            begin
                ofs_raddr  = OA_W'(cur_node) + 1'b1;
                ptr_next   = ofs_rdata;
                state_next = S_OFS_C;
            end

            S_OFS_C:
            begin
                if (32'(ofs_rdata) > EDGE_COUNT)
                begin
                    end_next = OFS_W'(EDGE_COUNT);
                end
                else
                begin
                    end_next = ofs_rdata;
                end
                state_next = S_EDGE_RD;
            end

            S_EDGE_RD:
            begin
                if (ptr_reg >= end_reg)
                begin
                    if (phase_reg)
                    begin
                        clr_next   = '0;
                        state_next = S_CLR_RD;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        state_next = S_OFS_A;
                    end
                end
                else
                begin
                    edge_raddr = EA_W'(ptr_reg);
                    state_next = S_EDGE_CHK;
                end
            end

            S_EDGE_CHK:
            begin
                if (!(edge_tm < cutoff_reg))
                begin
                    // The walk of this node ends at the first late edge.
                    if (phase_reg)
                    begin
                        clr_next   = '0;
                        state_next = S_CLR_RD;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        state_next = S_OFS_A;
                    end
                end
                else if (32'(edge_nb) >= NODE_COUNT)
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_EDGE_RD;
                end
                else
                begin
                    mark_raddr = MA_W'(edge_nb);
                    nb_next    = edge_nb;
                    state_next = S_MARK_CHK;
                end
            end

            S_MARK_CHK:
            begin
                if (mark_rdata == MARK_NONE)
                begin
                    mark_we    = 1'b1;
                    mark_wdata = cur_bit;
                    uni_next   = uni_reg + 1'b1;
                    if (32'(mcnt_reg) < NODE_COUNT)
                    begin
                        list_we   = 1'b1;
                        mcnt_next = mcnt_reg + 1'b1;
                    end
                end
                else if (cur_bit == MARK_B && mark_rdata == MARK_A)
                begin
                    mark_we    = 1'b1;
                    mark_wdata = MARK_BOTH;
                    inter_next = inter_reg + 1'b1;
                end
                ptr_next   = ptr_reg + 1'b1;
                state_next = S_EDGE_RD;
            end

            S_CLR_RD:
            begin
                if (clr_reg >= mcnt_reg)
                begin
                    mcnt_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    list_raddr = clr_reg[MA_W-1:0];
                    state_next = S_CLR_WR;
                end
            end

            S_CLR_WR:
            begin
                mark_we    = 1'b1;
                mark_waddr = MA_W'(list_rdata);
                mark_wdata = MARK_NONE;
                clr_next   = clr_reg + 1'b1;
                state_next = S_CLR_RD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_next.union_count     = uni_reg;
                    out_next.intersect_count = inter_reg;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            phase_reg     <= 1'b0;
            sweep_reg     <= '0;
            mcnt_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sweep_reg     <= sweep_next;
            mcnt_reg      <= mcnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        end_reg    <= end_next;
        nb_reg     <= nb_next;
        uni_reg    <= uni_next;
        inter_reg  <= inter_next;
        node_a_reg <= node_a_next;
        node_b_reg <= node_b_next;
        cutoff_reg <= cutoff_next;
        out_reg    <= out_next;
    end

`ifndef SYNTH
    // The marked list never holds more entries than there are nodes.
    a_mcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(mcnt_reg) <= NODE_COUNT)
        else $error("marked count exceeds node count");

    // Every query leaves the marked list empty before new requests are taken.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (mcnt_reg == '0))
        else $error("marked list not emptied at end of query");

    // A shared neighbor is always also counted in the union.
    a_inter_le_union: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.intersect_count <= res.union_count))
        else $error("intersection count above union count");

    // The clearing pass never runs past the end of the marked list.
    a_clr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR_WR) |-> (clr_reg < mcnt_reg))
        else $error("clearing index past marked list");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_temporal_neighbor_union_intersect_core.sv
`default_nettype none

module tb_temporal_neighbor_union_intersect_core;

    import tnui_pkg::*;

    // The block has no code for func 3. Such a request must be swallowed
    // without a result.
    localparam func_t FUNC_UNUSED = func_t'(2'd3);

    localparam logic signed [TIME_W-1:0] TIME_MIN = 32'sh8000_0000;
    localparam logic signed [TIME_W-1:0] TIME_MAX = 32'sh7fff_ffff;

    // The stimulus stops once this many requests have gone in. Segments begun
    // with at most CALM_ITEMS left to go run with no random gaps on either side.
    localparam int ITEM_TARGET = 1550;
    localparam int CALM_ITEMS  = 150;

    // A query walks the edge entries written so far at most twice (under two
    // thousand are written), and the reset pass sweeps NODE_COUNT entries. The
    // watchdog limit is far above either.
    localparam int WATCHDOG_LIMIT = 200000;

    // Cycles to keep watching after the last expected result, so that a
    // stray extra result is still caught.
    localparam int END_SETTLE = 64;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    temporal_neighbor_union_intersect_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Shadow copy of the graph tables. The known flags record which entries
    // have been written, so that the stimulus never sends a query that would
    // read an entry the block holds no defined value for.
    logic [OFS_W-1:0]         ofs_mem    [NODE_COUNT+1];
    bit                       ofs_known  [NODE_COUNT+1];
    logic [NODE_W-1:0]        nbr_mem    [EDGE_COUNT];
    logic signed [TIME_W-1:0] tstamp_mem [EDGE_COUNT];
    bit                       edge_known [EDGE_COUNT];

    // Counts that the block still owes, oldest first.
    res_t expected_counts_q[$];

    // Nodes from recent graph segments, used as query targets.
    int live_nodes[$];

    // Window of cutoff times that splits the edge lists of the last segment.
    int          cut_lo;
    int unsigned cut_span;

    bit calm;
    bit send_gaps;

    int items_sent;
    int queries_sent;
    int writes_sent;
    int ignored_sent;
    int results_seen;
    int mismatches;
    int quiet_cycles;

    typedef struct {
        req_t stim;
        bit   typed;
        res_t counts;
    } dir_row_t;

    dir_row_t dir_rows[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Reset is held once at the start and never raised again.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Walks the edge lists of both nodes the way the block does. A neighbor
    // first seen from node_a gets mark 1 and one from node_b gets mark 2.
    // A neighbor already marked 1 that node_b reaches becomes 3 and counts
    // toward the intersection. The marks live only for one query, which
    // stands in for the clearing pass of the block. The return value is zero
    // if the walk touched a table entry that was never written.
    function automatic bit count_common_neighbors(
        input  logic [NODE_W-1:0]        node_a,
        input  logic [NODE_W-1:0]        node_b,
        input  logic signed [TIME_W-1:0] cutoff,
        output res_t                     counts
    );
        bit [1:0]    marks [NODE_COUNT];
        bit [1:0]    side;
        int unsigned uni;
        int unsigned inter;
        int          node;
        int          first;
        int          stop;
        int          nbr;
        int          pass;
        int          i;
        bit          reads_ok;

        uni      = 0;
        inter    = 0;
        reads_ok = 1'b1;
        for (pass = 0; pass < 2; pass++)
        begin
            node = (pass == 0) ? int'(node_a) : int'(node_b);
            side = (pass == 0) ? 2'b01 : 2'b10;
            if (node >= NODE_COUNT)
                continue;
            if (!ofs_known[node] || !ofs_known[node+1])
            begin
                reads_ok = 1'b0;
                continue;
            end
            first = int'(ofs_mem[node]);
            stop  = int'(ofs_mem[node+1]);
            // An end offset past the edge tables is clamped to their size.
            if (stop > EDGE_COUNT)
                stop = EDGE_COUNT;
            for (i = first; i < stop; i++)
            begin
                if (!edge_known[i])
                begin
                    reads_ok = 1'b0;
                    break;
                end
                // The walk ends at the first edge at or after the cutoff.
                if (!(tstamp_mem[i] < cutoff))
                    break;
                nbr = int'(nbr_mem[i]);
                // A neighbor outside the node range is passed over, and the
                // walk goes on.
                if (nbr >= NODE_COUNT)
                    continue;
                if (marks[nbr] == 2'b00)
                begin
                    marks[nbr] = side;
                    uni++;
                end
                else if (side == 2'b10 && marks[nbr] == 2'b01)
                begin
                    marks[nbr] = 2'b11;
                    inter++;
                end
            end
        end
        counts.union_count     = uni[COUNT_W-1:0];
        counts.intersect_count = inter[COUNT_W-1:0];
        return reads_ok;
    endfunction

    // Every field but func gets random content, and func starts as a query.
    // Callers then set the func code and whatever fields their request uses.
    function automatic req_t random_req();
        req_t        r;
        logic [31:0] w;

        r.func         = FUNC_QUERY;
        w              = $urandom;
        r.table_addr   = w[ADDR_W-1:0];
        w              = $urandom;
        r.offset_value = w[OFS_W-1:0];
        w              = $urandom;
        r.neighbor_id  = w[NODE_W-1:0];
        r.edge_time    = $urandom;
        w              = $urandom;
        r.node_a       = w[NODE_W-1:0];
        r.node_b       = w[NODE_W+15:16];
        r.cutoff_time  = $urandom;
        return r;
    endfunction

    // Sends one request and applies it to the shadow tables once it is
    // accepted. A query appends either the counts typed in by the caller or
    // the counts worked out by the walk above. Valid stays high from one
    // request into the next unless an idle burst is due.
    task automatic issue(input req_t r, input bit typed, input res_t typed_counts);
        res_t want;

        if (!calm && send_gaps && $urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        items_sent++;
        case (r.func)
            FUNC_WR_OFS:
            begin
                writes_sent++;
                if (r.table_addr <= NODE_COUNT)
                begin
                    ofs_mem[r.table_addr]   = r.offset_value;
                    ofs_known[r.table_addr] = 1'b1;
                end
            end
            FUNC_WR_EDGE:
            begin
                writes_sent++;
                if (r.table_addr < EDGE_COUNT)
                begin
                    nbr_mem[r.table_addr]    = r.neighbor_id;
                    tstamp_mem[r.table_addr] = r.edge_time;
                    edge_known[r.table_addr] = 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                queries_sent++;
                if (typed)
                    want = typed_counts;
                else
                    void'(count_common_neighbors(r.node_a, r.node_b,
                                                 r.cutoff_time, want));
                expected_counts_q = {expected_counts_q, want};
            end
            default:
                ignored_sent++;
        endcase
    endtask

    // Holds the request side idle until every owed result has been taken.
    // At least one edge always passes, so valid never falls and rises again
    // within one time step.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_counts_q.size() != 0);
    endtask

    task automatic add_row(
        input func_t                    func,
        input int                       addr,
        input int                       ofs,
        input int                       nbr,
        input logic signed [TIME_W-1:0] etime,
        input int                       na,
        input int                       nb,
        input logic signed [TIME_W-1:0] cut,
        input bit                       typed,
        input int                       uni,
        input int                       inter
    );
        dir_row_t row;

        row.stim                   = '0;
        row.stim.func              = func;
        row.stim.table_addr        = addr[ADDR_W-1:0];
        row.stim.offset_value      = ofs[OFS_W-1:0];
        row.stim.neighbor_id       = nbr[NODE_W-1:0];
        row.stim.edge_time         = etime;
        row.stim.node_a            = na[NODE_W-1:0];
        row.stim.node_b            = nb[NODE_W-1:0];
        row.stim.cutoff_time       = cut;
        row.typed                  = typed;
        row.counts.union_count     = uni[COUNT_W-1:0];
        row.counts.intersect_count = inter[COUNT_W-1:0];
        dir_rows = {dir_rows, row};
    endtask

    // A cutoff is either fully random, the largest time (the walk takes
    // whole lists), or drawn from the time window of the last segment, where
    // it cuts lists partway.
    function automatic logic signed [TIME_W-1:0] pick_cutoff();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return TIME_MAX;
            default: return cut_lo + int'($urandom_range(0, cut_span));
        endcase
    endfunction

    // Sends a query whose walk reads only written entries. With any_node set
    // the first tries use arbitrary nodes. The later tries use nodes of recent
    // segments, and a pair of equal nodes comes up now and then. If no try
    // gives a safe pair, no query is sent.
    task automatic issue_query(input bit any_node);
        req_t r;
        res_t scratch;
        int   tries;

        for (tries = 0; tries < 8; tries++)
        begin
            r      = random_req();
            r.func = FUNC_QUERY;
            if (!(any_node && tries < 4) && live_nodes.size() != 0)
            begin
                r.node_a = NODE_W'(live_nodes[$urandom_range(0, live_nodes.size() - 1)]);
                if ($urandom_range(0, 4) == 0)
                    r.node_b = r.node_a;
                else
                    r.node_b = NODE_W'(live_nodes[$urandom_range(0, live_nodes.size() - 1)]);
            end
            r.cutoff_time = pick_cutoff();
            if (count_common_neighbors(r.node_a, r.node_b, r.cutoff_time, scratch))
            begin
                issue(r, 1'b0, '0);
                return;
            end
        end
    endtask

    // Lays out a few consecutive nodes with short edge lists in one block of
    // edge entries, and writes their offsets and edges in either order.
    // Neighbors come mostly from a small pool, so lists overlap and repeat.
    // Timestamps either climb in small steps, so that a cutoff from the
    // window ends a walk partway, or are fully random.
    task automatic build_segment();
        req_t r;
        int   deg [8];
        int   n_nodes;
        int   first;
        int   total;
        int   base;
        int   pool;
        int   t;
        int   t_first;
        int   k;
        int   e;
        int   pass;
        int   prefix;
        bit   ramp;
        bit   edges_first;

        n_nodes = $urandom_range(1, 8);
        first   = $urandom_range(0, NODE_COUNT - n_nodes);
        total   = 0;
        for (k = 0; k < n_nodes; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                deg[k] = $urandom_range(24, 48);
            else
                deg[k] = $urandom_range(0, 10);
            total += deg[k];
        end
        base        = $urandom_range(0, EDGE_COUNT - total);
        pool        = $urandom_range(0, NODE_COUNT - 16);
        ramp        = 1'($urandom_range(0, 1));
        edges_first = 1'($urandom_range(0, 1));
        t           = int'($urandom_range(0, 200)) - 100;
        t_first     = t;

        for (pass = 0; pass < 2; pass++)
        begin
            if ((pass == 0) == edges_first)
            begin
                for (e = 0; e < total; e++)
                begin
                    r            = random_req();
                    r.func       = FUNC_WR_EDGE;
                    r.table_addr = ADDR_W'(base + e);
                    if ($urandom_range(0, 3) != 0)
                        r.neighbor_id = NODE_W'(pool + int'($urandom_range(0, 15)));
                    if (ramp)
                    begin
                        r.edge_time = t;
                        t += $urandom_range(1, 20);
                    end
                    issue(r, 1'b0, '0);
                end
            end
            else
            begin
                prefix = base;
                for (k = 0; k <= n_nodes; k++)
                begin
                    r              = random_req();
                    r.func         = FUNC_WR_OFS;
                    r.table_addr   = ADDR_W'(first + k);
                    r.offset_value = OFS_W'(prefix);
                    issue(r, 1'b0, '0);
                    if (k < n_nodes)
                        prefix += deg[k];
                end
            end
        end

        if (ramp)
        begin
            cut_lo   = t_first - 10;
            cut_span = t - t_first + 20;
        end
        else
        begin
            cut_lo   = $urandom;
            cut_span = 32'hffff_ffff;
        end
        for (k = 0; k < n_nodes; k++)
        begin
            live_nodes = {live_nodes, first + k};
            if (live_nodes.size() > 48)
                void'(live_nodes.pop_front());
        end
    endtask

    // Noise between segments: the unused func code, offset writes past the
    // table, offset and edge writes with random content anywhere (these may
    // spoil older segments, which the shadow tables follow), and queries that
    // try arbitrary nodes first.
    task automatic issue_noise();
        req_t r;

        r = random_req();
        case ($urandom_range(0, 4))
            0:
                r.func = FUNC_UNUSED;
            1:
            begin
                r.func       = FUNC_WR_OFS;
                r.table_addr = ADDR_W'($urandom_range(NODE_COUNT + 1, 2**ADDR_W - 1));
            end
            2:
            begin
                r.func       = FUNC_WR_OFS;
                r.table_addr = ADDR_W'($urandom_range(0, NODE_COUNT));
            end
            3:
                r.func = FUNC_WR_EDGE;
            default:
            begin
                issue_query(1'b1);
                return;
            end
        endcase
        issue(r, 1'b0, '0);
    endtask

    // Result sink. The ready signal drops in bursts at random. Long
    // stretches with no stalls come and go, and at the end of the run there
    // are none.
    initial
    begin : result_sink
        int hold;
        bit sink_gaps;

        hold      = 0;
        sink_gaps = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (!calm && sink_gaps && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 16);
            res_ready <= (hold == 0);
            if ($urandom_range(0, 255) == 0)
                sink_gaps = !sink_gaps;
        end
    end

    // Every accepted result is checked against the oldest owed counts.
    always @(posedge clk)
    begin
        if (res_valid === 1'b1 && res_ready === 1'b1)
        begin
            results_seen++;
            if (expected_counts_q.size() == 0)
            begin
                $error("result with no query outstanding: union_count %0d, intersect_count %0d",
                       res.union_count, res.intersect_count);
                mismatches++;
            end
            else
            begin
                res_t want;
                want = expected_counts_q.pop_front();
                if (res.union_count !== want.union_count)
                begin
                    $error("union_count: expected %0d, actual %0d",
                           want.union_count, res.union_count);
                    mismatches++;
                end
                if (res.intersect_count !== want.intersect_count)
                begin
                    $error("intersect_count: expected %0d, actual %0d",
                           want.intersect_count, res.intersect_count);
                    mismatches++;
                end
            end
        end
    end

    // The watchdog counts cycles in which neither channel moves a request or
    // a result, and gives up when the count reaches the limit.
    always @(posedge clk)
    begin
        if ((req_valid === 1'b1 && req_ready === 1'b1) ||
            (res_valid === 1'b1 && res_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int k;

        calm      = 1'b0;
        send_gaps = 1'b1;
        cut_lo    = 0;
        cut_span  = 100;

        // The directed rows use the top of the edge tables and the last
        // offset entry. Node 1023 owns edges 8189 to 8191, with the smallest,
        // zero and the largest timestamp. Its end offset is the largest
        // field value and gets clamped. Node 0 starts empty, and node 2 first
        // has a start past its end. Later rows give node 0 an edge and reach
        // edge 8190 from node 2.
        add_row(FUNC_WR_OFS,  0,    0,     0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_WR_OFS,  1,    0,     0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_QUERY,   0,    0,     0,    0,        0,    0,    0,        1, 0, 0);
        add_row(FUNC_WR_OFS,  1023, 8189,  0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_WR_OFS,  1024, 16383, 0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_WR_EDGE, 8189, 0,     1023, TIME_MIN, 0,    0,    0,        0, 0, 0);
        add_row(FUNC_WR_EDGE, 8190, 0,     0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_WR_EDGE, 8191, 0,     1023, TIME_MAX, 0,    0,    0,        0, 0, 0);
        add_row(FUNC_QUERY,   0,    0,     0,    0,        1023, 1023, TIME_MAX, 1, 2, 2);
        add_row(FUNC_QUERY,   0,    0,     0,    0,        1023, 0,    TIME_MIN, 1, 0, 0);
        add_row(FUNC_QUERY,   0,    0,     0,    0,        1023, 1023, 1,        1, 2, 2);
        add_row(FUNC_QUERY,   0,    0,     0,    0,        1023, 0,    0,        1, 1, 0);
        add_row(FUNC_UNUSED,  8191, 16383, 1023, -1,       1023, 1023, -1,       0, 0, 0);
        add_row(FUNC_WR_OFS,  1025, 0,     0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_WR_OFS,  8191, 0,     0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_QUERY,   0,    0,     0,    0,        1023, 0,    TIME_MAX, 1, 2, 0);
        add_row(FUNC_WR_OFS,  2,    8190,  0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_WR_OFS,  3,    8189,  0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_QUERY,   0,    0,     0,    0,        2,    1023, TIME_MAX, 1, 2, 0);
        add_row(FUNC_WR_OFS,  3,    8192,  0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_QUERY,   0,    0,     0,    0,        1023, 2,    TIME_MAX, 0, 0, 0);
        add_row(FUNC_WR_EDGE, 0,    0,     5,    -7,       0,    0,    0,        0, 0, 0);
        add_row(FUNC_WR_OFS,  1,    1,     0,    0,        0,    0,    0,        0, 0, 0);
        add_row(FUNC_QUERY,   0,    0,     0,    0,        0,    2,    -6,       0, 0, 0);

        // Requests are held off during reset and the mark-clearing pass that
        // follows it; the first handshake waits for ready.
        while (rst_n !== 1'b1)
            @(posedge clk);

        for (k = 0; k < dir_rows.size(); k++)
            issue(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].counts);

        // The sender pauses here until the block owes nothing.
        wait_for_results();

        while (items_sent < ITEM_TARGET)
        begin
            calm      = (items_sent >= ITEM_TARGET - CALM_ITEMS);
            send_gaps = !calm && ($urandom_range(0, 2) != 0);
            build_segment();
            repeat ($urandom_range(3, 8)) issue_query(1'b0);
            repeat ($urandom_range(0, 3)) issue_noise();
            if ($urandom_range(0, 5) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (END_SETTLE) @(posedge clk);

        $display("Sent %0d requests: %0d queries, %0d table writes, %0d with the unused code.",
                 items_sent, queries_sent, writes_sent, ignored_sent);
        $display("Checked %0d results under random stalls on both channels.", results_seen);
        if (mismatches == 0 && expected_counts_q.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            if (expected_counts_q.size() != 0)
                $error("%0d query results never arrived", expected_counts_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
